// ===== sv/assert_macros.svh =====
// Assertion macros shared by the point projection blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPDT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPDT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPDT_ASSERT(label, clk, rst, prop, msg)
`define PPDT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== sv/ppdt_pkg.sv =====
// Types and constants of the point projection and depth test block.
package ppdt_pkg;

   localparam int OP_W       = 2;
   localparam int COORD_W    = 7;
   localparam int GLYPH_W    = 8;
   localparam int CELL_W     = 13;
   localparam int DEPTH_W    = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TRIG_W     = 16;
   localparam int DIST_W     = 10;
   localparam int HOFS_W     = 8;

   localparam int MAC_A_W = 41;
   localparam int MAC_B_W = 17;
   localparam int MAC_P_W = MAC_A_W + MAC_B_W;
   localparam int ACC_W   = 66;

   localparam int ZQ_W  = 28;
   localparam int DIV_W = 27;

   localparam logic [OP_W-1:0] OP_PLOT       = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIN_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_C = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_C = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HOFS  = 3'd7;

   localparam logic [GLYPH_W-1:0] EMPTY_GLYPH = 8'd46;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_mode_type;

   typedef enum logic [2:0] {
      SH_0,
      SH_1,
      SH_13,
      SH_14,
      SH_28
   } shift_type;

   typedef struct packed {
      logic                       issue;
      logic signed [MAC_A_W-1:0]  a;
      logic signed [MAC_B_W-1:0]  b;
      shift_type                  shift;
      acc_mode_type               mode;
   } mac_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [ACC_W-1:0]  acc;
   } mac_stat_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DEPTH_W-1:0]  quotient;
   } div_stat_type;

endpackage

// ===== sv/ppdt_if.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
interface ppdt_req_if;
   import ppdt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;
   logic [GLYPH_W-1:0]         glyph_code;
   logic [CELL_W-1:0]          cell_index;
   modport source (output valid, operation, point_x, point_y, point_z, glyph_code,
                   cell_index, input ready);
   modport sink (input valid, operation, point_x, point_y, point_z, glyph_code,
                 cell_index, output ready);
endinterface

interface ppdt_rsp_if;
   import ppdt_pkg::*;
   logic                valid;
   logic                ready;
   logic [GLYPH_W-1:0]  cell_glyph;
   logic [DEPTH_W-1:0]  cell_depth;
   modport source (output valid, cell_glyph, cell_depth, input ready);
   modport sink (input valid, cell_glyph, cell_depth, output ready);
endinterface

interface ppdt_csr_if;
   import ppdt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ppdt_mac.sv =====
// Shared multiply-accumulate unit: one product per command, then accumulate.
`include "assert_macros.svh"
module ppdt_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  ppdt_pkg::mac_cmd_type   cmd,
   output ppdt_pkg::mac_stat_type  stat
);
   import ppdt_pkg::*;

   logic signed [MAC_P_W-1:0]  prod_ff, prod_in;
   shift_type                  shift_ff;
   acc_mode_type               mode_ff;
   logic                       valid_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       done_ff;
   logic signed [ACC_W-1:0]    ext;
   logic signed [ACC_W-1:0]    term;

   assign prod_in = cmd.a * cmd.b;
   assign ext     = ACC_W'(prod_ff);

   always_comb begin
      case (shift_ff)
         SH_1:    term = ext <<< 1;
         SH_13:   term = ext <<< 13;
         SH_14:   term = ext <<< 14;
         SH_28:   term = ext <<< 28;
         default: term = ext;
      endcase
      case (mode_ff)
         ACC_ADD: acc_in = acc_ff + term;
         ACC_SUB: acc_in = acc_ff - term;
         default: acc_in = term;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= cmd.issue;
         done_ff  <= valid_ff;
      end
      if (cmd.issue) begin
         prod_ff  <= prod_in;
         shift_ff <= cmd.shift;
         mode_ff  <= cmd.mode;
      end
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.acc  = acc_ff;

   `PPDT_ASSERT(a_mac_latency, clock, reset, cmd.issue |=> ##1 stat.done, "mac result late")
   `PPDT_ASSERT_ALWAYS(a_mac_reset, clock, reset |=> !stat.done, "mac done after reset")
endmodule

// ===== sv/ppdt_div.sv =====
// Restoring divider forming the Q1.24 reciprocal depth one bit per cycle.
`include "assert_macros.svh"
module ppdt_div (
   input  logic                    clock,
   input  logic                    reset,
   input  ppdt_pkg::div_cmd_type   cmd,
   output ppdt_pkg::div_stat_type  stat
);
   import ppdt_pkg::*;

   logic [DIV_W:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]    dvs_ff, dvs_in;
   logic [DEPTH_W-1:0]  q_ff, q_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_W+1:0]    diff;

   assign diff = {1'b0, rem_ff} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         // The dividend 2^38 contributes nothing before quotient bit 24.
         rem_in  = (DIV_W+1)'(16384);
         dvs_in  = cmd.divisor;
         q_in    = '0;
         cnt_in  = 5'(DEPTH_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W+1]) begin
            rem_in = {diff[DIV_W-1:0], 1'b0};
            q_in   = {q_ff[DEPTH_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-1:0], 1'b0};
            q_in   = {q_ff[DEPTH_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = q_ff;

   `PPDT_ASSERT(a_div_start_idle, clock, reset, cmd.start |-> !stat.busy, "divider restarted")
endmodule

// ===== sv/ppdt_store.sv =====
// Cell store of glyph and depth, with a clearing pass after reset.
`include "assert_macros.svh"
module ppdt_store #(
   parameter int CELLS = 7040,
   localparam int ADDR_W = $clog2(CELLS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [ppdt_pkg::GLYPH_W-1:0]   rd_glyph,
   output logic [ppdt_pkg::DEPTH_W-1:0]   rd_depth,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [ppdt_pkg::GLYPH_W-1:0]   wr_glyph,
   input  logic [ppdt_pkg::DEPTH_W-1:0]   wr_depth,
   output logic                           clearing
);
   import ppdt_pkg::*;

   logic [GLYPH_W-1:0]  glyph_mem [CELLS];
   logic [DEPTH_W-1:0]  depth_mem [CELLS];
   logic [ADDR_W-1:0]   clr_ff;
   logic                clearing_ff;
   logic                we;
   logic [ADDR_W-1:0]   wa;
   logic [GLYPH_W-1:0]  wg;
   logic [DEPTH_W-1:0]  wd;

   always_comb begin
      if (clearing_ff) begin
         we = 1'b1;
         wa = clr_ff;
         wg = EMPTY_GLYPH;
         wd = '0;
      end else begin
         we = wr_en;
         wa = wr_addr;
         wg = wr_glyph;
         wd = wr_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(CELLS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         glyph_mem[wa] <= wg;
         depth_mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_glyph <= glyph_mem[rd_addr];
         rd_depth <= depth_mem[rd_addr];
      end
   end

   assign clearing = clearing_ff;

   `PPDT_ASSERT(a_store_no_write_clear, clock, reset, clearing_ff |-> !wr_en, "write while clearing")
endmodule

// ===== sv/point_projection_depth_test.sv =====
// Top level of the point projection and depth test block.
// A plot request keeps the block busy after acceptance for twenty products of the
// shared multiply-accumulate unit, the division, a read and a conditional write.
// A near point is dropped after the first twelve products.
// A read request goes through the read, data and result states to its response, a cell
// beyond the store through the result state alone; a new one is taken only back in idle,
// which a waiting response can delay. Reset is synchronous; afterwards the store clears
// its COLUMNS*ROWS cells (7040 at the default size) one cell a cycle, accepting no request.
`include "assert_macros.svh"
module point_projection_depth_test #(
   parameter int COLUMNS    = 160,
   parameter int ROWS       = 44,
   parameter int PROJ_SCALE = 40
) (
   input logic          clock,
   input logic          reset,
   ppdt_req_if.sink     req_chan,
   ppdt_rsp_if.source   rsp_chan,
   ppdt_csr_if.sink     csr_chan
);
   import ppdt_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [31:0] CELLS_U = 32'(CELLS);

   // The plot computation is a fixed micro-program for the shared unit. Each step is
   // one product that is loaded into, added to or subtracted from the accumulator.
   // The rotation is factored through u = j*sA - k*cA, v = j*cA + k*sA and
   // w = u*sB + i*cB*2^14, which keeps every product within the unit's operand widths.
   typedef enum logic [4:0] {
      M_JSA, M_KCA_U, M_JCA, M_KSA_V, M_USB, M_ICB_W, M_ISB, M_UCB_Z,
      M_WCC, M_VSC_X, M_VCC, M_WSC_Y, M_XPS, M_TLO_X, M_THI_COL,
      M_YPS, M_TLO_Y, M_THI_ROW, M_COL, M_ROW_IDX
   } step_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_DIV, S_READ, S_DATA, S_RESULT
   } state_type;

   state_type  state_ff, state_in;
   step_type   step_ff, step_in;
   logic       pend_ff, pend_in;

   // Configuration registers.
   logic signed [TRIG_W-1:0]  sin_a_ff, cos_a_ff, sin_b_ff, cos_b_ff, sin_c_ff, cos_c_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic signed [HOFS_W-1:0]  hofs_ff;

   // The request being worked on.
   logic [OP_W-1:0]            op_ff, op_in;
   logic signed [COORD_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [GLYPH_W-1:0]         glyph_ff, glyph_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic                       zero_ff, zero_in;

   // Intermediate results of the micro-program.
   logic signed [23:0]          u_ff, u_in, v_ff, v_in;
   logic signed [MAC_A_W-1:0]   w_ff, w_in, t_ff, t_in;
   logic signed [ZQ_W-1:0]      zq_ff, zq_in, xr_ff, xr_in, yr_ff, yr_in;
   logic signed [ZQ_W-1:0]      col_ff, col_in, row_ff, row_in;
   logic [DEPTH_W-1:0]          ooz_ff, ooz_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0]    rsp_glyph_ff, rsp_glyph_in;
   logic [DEPTH_W-1:0]    rsp_depth_ff, rsp_depth_in;

   mac_cmd_type   mac_cmd;
   mac_stat_type  mac_stat;
   div_cmd_type   div_cmd;
   div_stat_type  div_stat;

   logic                     rd_en, wr_en, clearing;
   logic [GLYPH_W-1:0]       rd_glyph, wr_glyph;
   logic [DEPTH_W-1:0]       rd_depth, wr_depth;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ZQ_W-1:0]   quot, col_f, row_f;
   logic                     frac_nz;
   logic                     req_take;

   ppdt_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .stat  (mac_stat)
   );

   ppdt_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   ppdt_store #(
      .CELLS (CELLS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (addr_ff),
      .rd_glyph (rd_glyph),
      .rd_depth (rd_depth),
      .wr_en    (wr_en),
      .wr_addr  (addr_ff),
      .wr_glyph (wr_glyph),
      .wr_depth (wr_depth),
      .clearing (clearing)
   );

   assign req_chan.ready = (state_ff == S_IDLE) && !clearing;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_glyph = rsp_glyph_ff;
   assign rsp_chan.cell_depth = rsp_depth_ff;

   // Projection truncates toward zero. The integer offset has no fraction bits, so the
   // floor of the scaled product plus the offset, corrected by one for a negative sum
   // with a nonzero fraction, gives the truncated column or row.
   assign acc     = mac_stat.acc;
   assign quot    = ZQ_W'(acc >>> 38);
   assign frac_nz = (acc[37:0] != '0);
   assign col_f   = quot + ZQ_W'(COLUMNS / 2) + ZQ_W'(hofs_ff);
   assign row_f   = quot + ZQ_W'(ROWS / 2);

   // Operand selection for the step in flight.
   always_comb begin
      mac_cmd.issue = 1'b0;
      mac_cmd.a     = '0;
      mac_cmd.b     = '0;
      mac_cmd.shift = SH_0;
      mac_cmd.mode  = ACC_LOAD;
      unique case (step_ff) inside
         M_JSA: begin
            mac_cmd.a = MAC_A_W'(j_ff); mac_cmd.b = MAC_B_W'(sin_a_ff);
         end
         M_KCA_U: begin
            mac_cmd.a = MAC_A_W'(k_ff); mac_cmd.b = MAC_B_W'(cos_a_ff);
            mac_cmd.mode = ACC_SUB;
         end
         M_JCA: begin
            mac_cmd.a = MAC_A_W'(j_ff); mac_cmd.b = MAC_B_W'(cos_a_ff);
         end
         M_KSA_V: begin
            mac_cmd.a = MAC_A_W'(k_ff); mac_cmd.b = MAC_B_W'(sin_a_ff);
            mac_cmd.mode = ACC_ADD;
         end
         M_USB: begin
            mac_cmd.a = MAC_A_W'(u_ff); mac_cmd.b = MAC_B_W'(sin_b_ff);
         end
         M_ICB_W: begin
            mac_cmd.a = MAC_A_W'(i_ff); mac_cmd.b = MAC_B_W'(cos_b_ff);
            mac_cmd.shift = SH_14; mac_cmd.mode = ACC_ADD;
         end
         M_ISB: begin
            mac_cmd.a = MAC_A_W'(i_ff); mac_cmd.b = MAC_B_W'(sin_b_ff);
            mac_cmd.shift = SH_28;
         end
         M_UCB_Z: begin
            mac_cmd.a = MAC_A_W'(u_ff); mac_cmd.b = MAC_B_W'(cos_b_ff);
            mac_cmd.shift = SH_14; mac_cmd.mode = ACC_SUB;
         end
         M_WCC: begin
            mac_cmd.a = w_ff; mac_cmd.b = MAC_B_W'(cos_c_ff);
         end
         M_VSC_X: begin
            mac_cmd.a = MAC_A_W'(v_ff); mac_cmd.b = MAC_B_W'(sin_c_ff);
            mac_cmd.shift = SH_14; mac_cmd.mode = ACC_ADD;
         end
         M_VCC: begin
            mac_cmd.a = MAC_A_W'(v_ff); mac_cmd.b = MAC_B_W'(cos_c_ff);
            mac_cmd.shift = SH_14;
         end
         M_WSC_Y: begin
            mac_cmd.a = w_ff; mac_cmd.b = MAC_B_W'(sin_c_ff);
            mac_cmd.mode = ACC_SUB;
         end
         M_XPS: begin
            mac_cmd.a = MAC_A_W'(xr_ff); mac_cmd.b = MAC_B_W'(PROJ_SCALE);
            mac_cmd.shift = SH_1;
         end
         M_TLO_X, M_TLO_Y: begin
            mac_cmd.a = t_ff; mac_cmd.b = MAC_B_W'(ooz_ff[12:0]);
         end
         M_THI_COL: begin
            mac_cmd.a = t_ff; mac_cmd.b = MAC_B_W'(ooz_ff[DEPTH_W-1:13]);
            mac_cmd.shift = SH_13; mac_cmd.mode = ACC_ADD;
         end
         M_YPS: begin
            mac_cmd.a = MAC_A_W'(yr_ff); mac_cmd.b = MAC_B_W'(PROJ_SCALE);
         end
         M_THI_ROW: begin
            mac_cmd.a = t_ff; mac_cmd.b = MAC_B_W'(ooz_ff[DEPTH_W-1:13]);
            mac_cmd.shift = SH_13; mac_cmd.mode = ACC_ADD;
         end
         M_COL: begin
            mac_cmd.a = MAC_A_W'(col_ff); mac_cmd.b = MAC_B_W'(1);
         end
         M_ROW_IDX: begin
            mac_cmd.a = MAC_A_W'(row_ff); mac_cmd.b = MAC_B_W'(COLUMNS);
            mac_cmd.mode = ACC_ADD;
         end
         default: begin
            mac_cmd.a = '0;
         end
      endcase
      mac_cmd.issue = (state_ff == S_MAC) && !pend_ff;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      glyph_in     = glyph_ff;
      addr_in      = addr_ff;
      zero_in      = zero_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      zq_in        = zq_ff;
      xr_in        = xr_ff;
      yr_in        = yr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ooz_in       = ooz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_depth_in = rsp_depth_ff;
      div_cmd.start   = 1'b0;
      div_cmd.divisor = DIV_W'(zq_ff);
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_glyph = glyph_ff;
      wr_depth = ooz_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_chan.operation;
               i_in     = req_chan.point_x;
               j_in     = req_chan.point_y;
               k_in     = req_chan.point_z;
               glyph_in = req_chan.glyph_code;
               addr_in  = ADDR_W'(req_chan.cell_index);
               zero_in  = 1'b0;
               case (req_chan.operation) inside
                  OP_PLOT: begin
                     state_in = S_MAC;
                     step_in  = M_JSA;
                     pend_in  = 1'b0;
                  end
                  OP_READ, OP_READ_CLEAR: begin
                     if (32'(req_chan.cell_index) < CELLS_U) begin
                        state_in = S_READ;
                     end else begin
                        // A cell beyond the store reads as glyph zero and depth zero and is never cleared.
                        zero_in  = 1'b1;
                        state_in = S_RESULT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MAC: begin
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else if (mac_stat.done) begin
               pend_in = 1'b0;
               step_in = step_type'(step_ff + 5'd1);
               case (step_ff)
                  M_KCA_U:   u_in   = acc[23:0];
                  M_KSA_V:   v_in   = acc[23:0];
                  M_ICB_W:   w_in   = acc[MAC_A_W-1:0];
                  M_UCB_Z:   zq_in  = ZQ_W'(acc >>> 28) + ZQ_W'({dist_ff, 14'b0});
                  M_VSC_X:   xr_in  = ZQ_W'(acc >>> 28);
                  M_WSC_Y:   yr_in  = ZQ_W'(acc >>> 28);
                  M_XPS:     t_in   = acc[MAC_A_W-1:0];
                  M_YPS:     t_in   = acc[MAC_A_W-1:0];
                  M_THI_COL: col_in = col_f + ZQ_W'(col_f[ZQ_W-1] && frac_nz);
                  M_THI_ROW: row_in = row_f + ZQ_W'(row_f[ZQ_W-1] && frac_nz);
                  default: begin
                     u_in = u_ff;
                  end
               endcase
               if (step_ff == M_WSC_Y) begin
                  // A point nearer than unit depth is dropped before the division.
                  if (zq_ff < ZQ_W'(16384)) begin
                     state_in = S_IDLE;
                  end else begin
                     div_cmd.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               if (step_ff == M_ROW_IDX) begin
                  addr_in = acc[ADDR_W-1:0];
                  if (!acc[ACC_W-1] && (acc < ACC_W'(CELLS))) begin
                     state_in = S_READ;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               ooz_in   = div_stat.quotient;
               step_in  = M_XPS;
               pend_in  = 1'b0;
               state_in = S_MAC;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_DATA;
         end
         S_DATA: begin
            if (op_ff == OP_PLOT) begin
               // Only a strictly nearer point replaces the stored one.
               wr_en    = (ooz_ff > rd_depth);
               state_in = S_IDLE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_glyph_in = zero_ff ? '0 : rd_glyph;
               rsp_depth_in = zero_ff ? '0 : rd_depth;
               if ((op_ff == OP_READ_CLEAR) && !zero_ff) begin
                  wr_en    = 1'b1;
                  wr_glyph = EMPTY_GLYPH;
                  wr_depth = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= M_JSA;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sin_a_ff     <= '0;
         cos_a_ff     <= TRIG_W'(16384);
         sin_b_ff     <= '0;
         cos_b_ff     <= TRIG_W'(16384);
         sin_c_ff     <= '0;
         cos_c_ff     <= TRIG_W'(16384);
         dist_ff      <= DIST_W'(100);
         hofs_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               CSR_SIN_A: sin_a_ff <= csr_chan.data;
               CSR_COS_A: cos_a_ff <= csr_chan.data;
               CSR_SIN_B: sin_b_ff <= csr_chan.data;
               CSR_COS_B: cos_b_ff <= csr_chan.data;
               CSR_SIN_C: sin_c_ff <= csr_chan.data;
               CSR_COS_C: cos_c_ff <= csr_chan.data;
               CSR_DIST:  dist_ff  <= csr_chan.data[DIST_W-1:0];
               CSR_HOFS:  hofs_ff  <= csr_chan.data[HOFS_W-1:0];
               default:   hofs_ff  <= hofs_ff;
            endcase
         end
      end
      op_ff        <= op_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      glyph_ff     <= glyph_in;
      addr_ff      <= addr_in;
      zero_ff      <= zero_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      t_ff         <= t_in;
      zq_ff        <= zq_in;
      xr_ff        <= xr_in;
      yr_ff        <= yr_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      ooz_ff       <= ooz_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   `PPDT_ASSERT(a_div_only_far, clock, reset, (state_ff == S_DIV) |-> (zq_ff >= ZQ_W'(16384)), "near point divided")
endmodule
